>>> rtl/point_in_polygon_test_unit_defines.svh
// Assertion macros for the point-in-polygon test unit checker.
`ifndef POINT_IN_POLYGON_TEST_UNIT_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PIP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PIP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pip_pkg.sv
// Shared constants, types and states for the point-in-polygon test unit.
package pip_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int COORD_WIDTH  = 32;

  localparam int IDX_W   = $clog2(MAX_VERTICES);
  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * DIFF_W;

  // word field widths
  localparam int CFG_W         = 6;
  localparam int FLD_IDX_W     = 5;
  localparam int FLD_COORD_W   = 32;
  localparam int IN_TDATA_W    = ((FLD_IDX_W + 2 * FLD_COORD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W   = 8;
  localparam int FLD_X_LSB     = FLD_IDX_W;
  localparam int FLD_Y_LSB     = FLD_IDX_W + FLD_COORD_W;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_JREAD,
    ST_JCAP,
    ST_DIFF,
    ST_MULL,
    ST_MULR,
    ST_CMP,
    ST_DONE
  } pip_state_t;

  typedef struct packed {
    logic start;      // latch query point, clear parity
    logic load_j;     // take first closing vertex as previous vertex
    logic load_diff;  // form edge differences from vertex i
    logic mul_l;      // product (px - xi) * (yj - yi)
    logic mul_r;      // product (xj - xi) * (py - yi)
    logic cmp;        // compare products, update parity
  } pip_ctl_t;

endpackage

>>> rtl/pip_edge_unit.sv
// Edge test datapath: differences, one shared multiplier, compare, parity.
module pip_edge_unit
  import pip_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  pip_ctl_t                      ctl,
  input  logic signed [COORD_WIDTH-1:0] pt_x,
  input  logic signed [COORD_WIDTH-1:0] pt_y,
  input  logic signed [COORD_WIDTH-1:0] rd_x,
  input  logic signed [COORD_WIDTH-1:0] rd_y,
  output logic                          parity
);

  logic signed [COORD_WIDTH-1:0] px, py, xj, yj;
  logic signed [DIFF_W-1:0]      dxp, dd, dxe, dyp;
  logic                          straddle, d_pos;
  logic signed [DIFF_W-1:0]      mul_a, mul_b;
  logic signed [PROD_W-1:0]      prod, lhs;
  logic                          toggle;

  assign mul_a = ctl.mul_l ? dxp : dxe;
  assign mul_b = ctl.mul_l ? dd : dyp;

  // lhs holds (px-xi)*d, prod holds (xj-xi)*(py-yi); flip the test when d < 0
  assign toggle = straddle && (d_pos ? (lhs <= prod) : (prod <= lhs));

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      px <= pt_x;
      py <= pt_y;
    end
    if (ctl.load_j) begin
      xj <= rd_x;
      yj <= rd_y;
    end
    if (ctl.load_diff) begin
      dxp      <= DIFF_W'(px) - DIFF_W'(rd_x);
      dd       <= DIFF_W'(yj) - DIFF_W'(rd_y);
      dxe      <= DIFF_W'(xj) - DIFF_W'(rd_x);
      dyp      <= DIFF_W'(py) - DIFF_W'(rd_y);
      straddle <= (rd_y >= py) != (yj >= py);
      d_pos    <= yj > rd_y;
      // vertex i becomes the previous vertex of the next edge
      xj       <= rd_x;
      yj       <= rd_y;
    end
    if (ctl.mul_l || ctl.mul_r) begin
      prod <= mul_a * mul_b;
    end
    if (ctl.mul_r) begin
      lhs <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
    end else if (ctl.start) begin
      parity <= 1'b0;
    end else if (ctl.cmp && toggle) begin
      parity <= ~parity;
    end
  end

endmodule

>>> rtl/point_in_polygon_test_unit.sv
// Point-in-polygon test unit top level: vertex table, sequencer, result register.
//
// Input words on s_axis: tuser selects the kind (0 load vertex, 1 query point).
// A load writes tdata's x/y into table slot vertex_index and gives no result;
// the unit stays ready. A query gives one result word on m_axis, with tdata
// bit 0 = 1 when the point is inside by the even-odd rule. vertex_count is
// written through cfg_wr_en/cfg_wr_data; the user must write it only while
// idle, as the unit itself does not enforce this. Values above the table size
// count as the full table. A query first fetches the closing vertex, then
// walks the edges on one shared multiplier (difference, two products, compare
// per edge). s_axis_tready stays low during a query. The next word is taken
// the cycle after the result is loaded; loads run one per cycle while idle.
// The result sits in an output register; while it waits, loads are accepted
// and a new query may run, but a finished query holds until the register is
// free. Reset clears the sequencer, vertex_count and the output valid; the
// vertex table is not cleared and must be loaded before use.
module point_in_polygon_test_unit
  import pip_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [4:0] vertex_index, [36:5] coord_x, [68:37] coord_y, rest zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] kind
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] inside_res, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data
);

  pip_state_t state, state_next;
  pip_ctl_t   ctl;

  logic [CFG_W-1:0]  vertex_count;
  logic [CNT_W-1:0]  n_eff, n_last;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [IDX_W-1:0]  rd_addr;
  logic              out_valid, out_res, out_load;
  logic              in_acc, parity;

  logic [FLD_IDX_W-1:0]          in_idx;
  logic signed [COORD_WIDTH-1:0] in_x, in_y;

  logic signed [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] rd_x, rd_y;

  assign in_idx = s_axis_tdata[FLD_IDX_W-1:0];
  assign in_x   = s_axis_tdata[FLD_X_LSB +: COORD_WIDTH];
  assign in_y   = s_axis_tdata[FLD_Y_LSB +: COORD_WIDTH];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign n_eff  = (int'(vertex_count) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                      : CNT_W'(vertex_count);
  assign n_last = n_eff - CNT_W'(1);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  // vertex table, registered read
  always_ff @(posedge clk) begin
    if (in_acc && s_axis_tuser == KIND_LOAD && int'(in_idx) < MAX_VERTICES) begin
      mem_x[IDX_W'(in_idx)] <= in_x;
      mem_y[IDX_W'(in_idx)] <= in_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= parity;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctl        = '0;
    out_load   = 1'b0;
    rd_addr    = cnt[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        if (in_acc && s_axis_tuser == KIND_QUERY) begin
          ctl.start  = 1'b1;
          cnt_next   = '0;
          state_next = (n_eff == '0) ? ST_DONE : ST_JREAD;
        end
      end
      ST_JREAD: begin
        rd_addr    = n_last[IDX_W-1:0];
        state_next = ST_JCAP;
      end
      ST_JCAP: begin
        ctl.load_j = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        ctl.load_diff = 1'b1;
        state_next    = ST_MULL;
      end
      ST_MULL: begin
        ctl.mul_l  = 1'b1;
        state_next = ST_MULR;
      end
      ST_MULR: begin
        ctl.mul_r  = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        ctl.cmp  = 1'b1;
        // fetch the next vertex so it is ready in ST_DIFF
        rd_addr  = cnt[IDX_W-1:0] + IDX_W'(1);
        cnt_next = cnt + CNT_W'(1);
        state_next = (cnt == n_last) ? ST_DONE : ST_DIFF;
      end
      ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  pip_edge_unit u_edge (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .pt_x   (in_x),
    .pt_y   (in_y),
    .rd_x   (rd_x),
    .rd_y   (rd_y),
    .parity (parity)
  );

endmodule

>>> rtl/pip_checker.sv
// Port-level checker for the point-in-polygon test unit, bound to the top level.
`include "point_in_polygon_test_unit_defines.svh"

module pip_checker
  import pip_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic q_acc, l_acc;

  assign q_acc = s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_QUERY;
  assign l_acc = s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_LOAD;

  `PIP_ASSERT_NEXT(a_query_busy, clk, rst, q_acc, !s_axis_tready, "ready after query")
  `PIP_ASSERT_NEXT(a_load_ready, clk, rst, l_acc, s_axis_tready, "busy after load")
  `PIP_ASSERT_NOW(a_result_from_query, clk, rst, $rose(m_axis_tvalid),
                  $past(!s_axis_tready), "result word without a running query")
  `PIP_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "stalled result word changed")

endmodule

bind point_in_polygon_test_unit pip_checker u_pip_checker (.*);

>>> tb/point_in_polygon_test_unit_tb.sv
// Testbench for the point-in-polygon test unit: random polygons checked against an even-odd predictor.
module point_in_polygon_test_unit_tb;
  import pip_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 6;
  localparam int TOTAL_WORDS  = 1950;
  localparam int CALM_AFTER   = 1800;
  localparam int QUERY_CYCLES = 4 * MAX_VERTICES + 3;
  localparam int DRAIN_CYCLES = QUERY_CYCLES + 16;
  localparam int LONG_HOLD    = 600;
  localparam int HOLD_AT      = 150;
  localparam int STALL_LIMIT  = 4 * (LONG_HOLD + QUERY_CYCLES + DRAIN_CYCLES);
  localparam int PRED_W       = 68;
  localparam logic signed [FLD_COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [FLD_COORD_W-1:0] C_MAX = 32'sh7fff_ffff;

  typedef enum int {SPAN_FULL, SPAN_WIDE, SPAN_TIGHT, SPAN_CORNER} coord_span_t;

  typedef struct {
    logic                          kind;
    logic [FLD_IDX_W-1:0]          slot;
    logic signed [FLD_COORD_W-1:0] x;
    logic signed [FLD_COORD_W-1:0] y;
  } poly_word_t;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [4:0] vertex_index, [36:5] coord_x, [68:37] coord_y, rest zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // [0] kind
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [0] inside_res, rest zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_wr_en     = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data   = '0;

  // predictor state
  logic signed [FLD_COORD_W-1:0] vx_store [MAX_VERTICES];
  logic signed [FLD_COORD_W-1:0] vy_store [MAX_VERTICES];
  logic [CFG_W-1:0]              vcount_cfg = '0;
  bit                            inside_expect_q [$];

  poly_word_t pending_words [$];
  poly_word_t cur_word;
  int         words_queued   = 0;
  int         words_accepted = 0;
  int         send_gap       = 0;
  int         ready_gap      = 0;
  int         hold_cnt       = 0;
  bit         hold_done      = 1'b0;
  int         results_seen   = 0;
  int         stall_cycles   = 0;
  int         errors         = 0;
  bit         calm           = 1'b0;

  point_in_polygon_test_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Exact crossing test: px - xi <= (xj - xi) * (py - yi) / (yj - yi),
  // cross-multiplied with the inequality flipped for a falling edge.
  function automatic bit edge_crosses(logic signed [FLD_COORD_W-1:0] pt_x,
                                      logic signed [FLD_COORD_W-1:0] pt_y,
                                      int i, int j);
    logic signed [PRED_W-1:0] px, py, xi, yi, xj, yj, d, lhs, rhs;
    px = PRED_W'(pt_x);
    py = PRED_W'(pt_y);
    xi = PRED_W'(vx_store[i]);
    yi = PRED_W'(vy_store[i]);
    xj = PRED_W'(vx_store[j]);
    yj = PRED_W'(vy_store[j]);
    if ((yi >= py) == (yj >= py)) return 1'b0;
    d   = yj - yi;
    lhs = (px - xi) * d;
    rhs = (xj - xi) * (py - yi);
    return (d > 0) ? (lhs <= rhs) : (rhs <= lhs);
  endfunction

  function automatic void predict_word(poly_word_t w);
    int n, j;
    bit parity;
    if (w.kind == KIND_LOAD) begin
      vx_store[w.slot] = w.x;
      vy_store[w.slot] = w.y;
      return;
    end
    n      = (int'(vcount_cfg) > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_cfg);
    parity = 1'b0;
    j      = n - 1;
    for (int i = 0; i < n; i++) begin
      if (edge_crosses(w.x, w.y, i, j)) parity = !parity;
      j = i;
    end
    inside_expect_q.insert(inside_expect_q.size(), parity);
  endfunction

  function automatic logic signed [FLD_COORD_W-1:0] pick_coord(coord_span_t span);
    int v;
    case (span)
      SPAN_WIDE: begin
        v = $urandom_range(0, 2000000);
        return v - 1000000;
      end
      SPAN_TIGHT: begin
        // small grid, so shared y values and points on edges are common
        v = $urandom_range(0, 16);
        return v - 8;
      end
      SPAN_CORNER: begin
        case ($urandom_range(0, 6))
          0: return C_MIN;
          1: return C_MAX;
          2: return 0;
          3: return -1;
          4: return 1;
          5: return C_MIN + 1;
          default: return C_MAX - 1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(logic kind, int slot,
                           logic signed [FLD_COORD_W-1:0] x,
                           logic signed [FLD_COORD_W-1:0] y);
    poly_word_t w;
    w.kind = kind;
    w.slot = FLD_IDX_W'(slot);
    w.x    = x;
    w.y    = y;
    pending_words.insert(pending_words.size(), w);
    words_queued++;
  endtask

  // wait until the unit is idle: all words taken, all results back, last query done
  task automatic settle();
    while (words_accepted != words_queued) @(posedge clk);
    while (inside_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(int v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(v);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    vcount_cfg = CFG_W'(v);
  endtask

  // sender
  always @(posedge clk) begin : drive_proc
    poly_word_t w;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_word(cur_word);
        words_accepted <= words_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!calm && hold_cnt == 0 && $urandom_range(0, 7) == 0) begin
          send_gap      <= $urandom_range(0, 4);
          s_axis_tvalid <= 1'b0;
        end else begin
          w = pending_words.pop_front();
          cur_word      <= w;
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= w.kind;
          s_axis_tdata  <= {{(IN_TDATA_W - FLD_Y_LSB - FLD_COORD_W){1'b0}}, w.y, w.x, w.slot};
        end
      end
    end
  end

  // receiver ready, with one long hold-off to back the unit up
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_gap     <= 0;
      hold_cnt      <= 0;
      hold_done     <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done     <= 1'b1;
      hold_cnt      <= LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap     <= ready_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      ready_gap     <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result check and watchdog
  always @(posedge clk) begin : check_proc
    bit exp_inside;
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (inside_expect_q.size() == 0) begin
          $error("result word with no query waiting: inside_res=%0d", m_axis_tdata[0]);
          errors++;
        end else begin
          exp_inside = inside_expect_q.pop_front();
          if (m_axis_tdata[0] !== exp_inside) begin
            $error("inside_res mismatch: expected %0d, actual %0d",
                   exp_inside, m_axis_tdata[0]);
            errors++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int          n;
    int          per_phase;
    int          phase;
    coord_span_t span;
    logic [CFG_W-1:0] cnt;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // empty polygon always answers outside
    set_vertex_count(0);
    push_word(KIND_QUERY, 0, 0, 0);
    push_word(KIND_QUERY, 31, C_MIN, C_MAX);
    // full-range square
    push_word(KIND_LOAD, 0, C_MIN, C_MIN);
    push_word(KIND_LOAD, 1, C_MAX, C_MIN);
    push_word(KIND_LOAD, 2, C_MAX, C_MAX);
    push_word(KIND_LOAD, 3, C_MIN, C_MAX);
    settle();
    set_vertex_count(4);
    push_word(KIND_QUERY, 0, 0, 0);
    push_word(KIND_QUERY, 0, C_MIN, 0);
    push_word(KIND_QUERY, 0, C_MAX, 0);
    push_word(KIND_QUERY, 0, 0, C_MAX);
    push_word(KIND_QUERY, 0, 0, C_MIN);
    push_word(KIND_QUERY, 0, C_MAX, C_MAX);
    push_word(KIND_QUERY, 0, -1, 1);
    settle();
    // triangle, then degenerate outlines
    set_vertex_count(3);
    push_word(KIND_QUERY, 0, 0, 0);
    push_word(KIND_QUERY, 0, 1, -1);
    push_word(KIND_QUERY, 0, C_MAX, C_MIN + 1);
    settle();
    set_vertex_count(1);
    push_word(KIND_QUERY, 0, C_MIN, C_MIN);
    settle();
    set_vertex_count(2);
    push_word(KIND_QUERY, 0, 0, 0);
    push_word(KIND_LOAD, 31, C_MAX, C_MIN);
    settle();

    // every slot written before any larger outline is used
    for (int k = 0; k < MAX_VERTICES; k++) push_word(KIND_LOAD, k, $urandom, $urandom);

    phase = 0;
    while (words_queued < TOTAL_WORDS) begin
      case (phase)
        0: cnt = 6'd63;
        1: cnt = CFG_W'(MAX_VERTICES);
        2: cnt = CFG_W'(MAX_VERTICES + 1);
        default: begin
          case ($urandom_range(0, 9))
            0: cnt = CFG_W'($urandom_range(0, 2));
            1: cnt = CFG_W'($urandom_range(MAX_VERTICES + 1, 63));
            2: cnt = CFG_W'(MAX_VERTICES);
            default: cnt = CFG_W'($urandom_range(3, 12));
          endcase
        end
      endcase
      if (words_queued >= CALM_AFTER) calm = 1'b1;
      settle();
      set_vertex_count(int'(cnt));
      span = coord_span_t'($urandom_range(0, 3));
      n    = (int'(cnt) > MAX_VERTICES) ? MAX_VERTICES : int'(cnt);
      for (int k = 0; k < n; k++) push_word(KIND_LOAD, k, pick_coord(span), pick_coord(span));
      per_phase = $urandom_range(15, 40);
      for (int k = 0; k < per_phase; k++) begin
        if ($urandom_range(0, 4) == 0)
          push_word(KIND_LOAD, $urandom_range(0, 31), pick_coord(span), pick_coord(span));
        else if ($urandom_range(0, 9) == 0)
          push_word(KIND_QUERY, $urandom, $urandom, $urandom);
        else
          push_word(KIND_QUERY, $urandom, pick_coord(span), pick_coord(span));
      end
      phase++;
    end
    settle();

    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/pip_pkg.sv
rtl/pip_edge_unit.sv
rtl/point_in_polygon_test_unit.sv
rtl/pip_checker.sv
tb/point_in_polygon_test_unit_tb.sv
